// ===== sv/mcmc_pkg.sv =====
// Shared types and constants for the matrix chain cost engine.
package mcmc_pkg;

  localparam int MAX_MATRICES_DEF = 64;
  localparam int DIM_BITS_DEF     = 16;
  localparam int COST_W           = 54;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [15:0] dim;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflow;
  } result_t;

  // controls from the sequencer to the cost datapath
  typedef struct packed {
    logic mul1;     // form d(i-1)*d(k) and sum of subcosts
    logic mul2;     // times d(j), saturate
    logic acc;      // add, compare, keep minimum
    logic first;    // first split of this cell
    logic zero_ik;  // left subchain is a single matrix
    logic zero_kj;  // right subchain is a single matrix
  } eval_ctrl_t;

endpackage

// ===== sv/mcmc_eval.sv =====
// Split-point cost datapath: product, saturating sums and running minimum.
module mcmc_eval
  import mcmc_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                clk,
  input  eval_ctrl_t          ctrl,
  input  logic [DIM_BITS-1:0] dim_a,
  input  logic [DIM_BITS-1:0] dim_k,
  input  logic [DIM_BITS-1:0] dim_c,
  input  logic [COST_W-1:0]   cost_ik,
  input  logic [COST_W-1:0]   cost_kj,
  output logic [COST_W-1:0]   best
);

  localparam int AB_W = 2 * DIM_BITS;
  localparam int PW   = (3 * DIM_BITS > COST_W + 1) ? 3 * DIM_BITS : COST_W + 1;

  logic [AB_W-1:0]   ab;
  logic [COST_W-1:0] sub_sum;
  logic [COST_W-1:0] prod;
  logic [COST_W-1:0] lhs, rhs;
  logic [COST_W:0]   sum1, sum2;
  logic [PW-1:0]     full;
  logic [COST_W-1:0] t;

  always_comb begin
    lhs  = ctrl.zero_ik ? '0 : cost_ik;
    rhs  = ctrl.zero_kj ? '0 : cost_kj;
    sum1 = {1'b0, lhs} + {1'b0, rhs};
    full = PW'(ab) * PW'(dim_c);
    sum2 = {1'b0, sub_sum} + {1'b0, prod};
    t    = sum2[COST_W] ? COST_MAX : sum2[COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul1) begin
      ab      <= AB_W'(dim_a) * AB_W'(dim_k);
      sub_sum <= sum1[COST_W] ? COST_MAX : sum1[COST_W-1:0];
    end
    if (ctrl.mul2) begin
      prod <= (full > PW'(COST_MAX)) ? COST_MAX : full[COST_W-1:0];
    end
    if (ctrl.acc && (ctrl.first || t < best)) begin
      best <= t;
    end
  end

endmodule

// ===== sv/matrix_chain_min_cost_core.sv =====
// Matrix chain minimum-cost engine: dimension store, cost table and sequencer.
//
// Usage: dimensions d0..dn arrive one per transaction on item (start high,
// busy low); item.last marks the final one. Loading accepts one dimension per
// cycle. On the last dimension the block raises busy and fills the
// interval cost table bottom-up by chain length, then drives result for
// exactly one cycle with result_valid high. The receiver cannot stall: the
// result must be taken in that cycle.
// A chain of fewer than three stored dimensions returns cost 0 in the cycle
// after the last transaction, busy never rising. Otherwise each table cell
// (i,j) goes through operand fetch (S_INIT, S_GETA, S_GETC), one pass of
// S_RD, S_MUL1, S_MUL2 and S_ACC per split point through the shared
// multiply/add datapath, and write back (S_WR). The run time of the table
// is set by the single split-point datapath and the one read port of the
// dimension store.
// Dimensions beyond MAX_MATRICES+1 are dropped and flagged in result.overflow.
// Reset clears the load count, the overflow flag and the sequencer; the two
// memories are not cleared: every cell whose value is used is written first.
module matrix_chain_min_cost_core
  import mcmc_pkg::*;
#(
  parameter int MAX_MATRICES = MAX_MATRICES_DEF,
  parameter int DIM_BITS     = DIM_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    result_valid,
  output result_t result
);

  localparam int DIM_DEPTH = MAX_MATRICES + 1;
  localparam int DAW       = $clog2(DIM_DEPTH);
  localparam int CW        = $clog2(MAX_MATRICES + 2);
  localparam int AW        = $clog2(MAX_MATRICES * MAX_MATRICES);

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_INIT = 9'b000000010,
    S_GETA = 9'b000000100,
    S_GETC = 9'b000001000,
    S_RD   = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_MUL2 = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_WR   = 9'b100000000
  } state_t;

  state_t state;

  logic [CW-1:0] count, count_next;
  logic          ovf;
  logic [CW-1:0] m;     // number of matrices in the chain
  logic [CW-1:0] len;   // current chain length
  logic [CW-1:0] i;     // first matrix of the cell
  logic [CW-1:0] k;     // split point
  logic [CW-1:0] j;     // last matrix of the cell

  logic [DIM_BITS-1:0] dim_mem [DIM_DEPTH];
  logic [DIM_BITS-1:0] dim_q;
  logic [DAW-1:0]      dim_raddr;
  logic [DIM_BITS-1:0] dim_a, dim_c;

  logic [COST_W-1:0] cost_mem [MAX_MATRICES * MAX_MATRICES];
  logic [COST_W-1:0] cost_q0, cost_q1;
  logic [AW-1:0]     addr_ik, addr_kj, addr_ij;

  logic              accept;
  logic              room;
  eval_ctrl_t        ctrl;
  logic [COST_W-1:0] best;

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign room   = (count < CW'(DIM_DEPTH));
  assign j      = i + len - CW'(1);

  always_comb begin
    count_next = room ? count + CW'(1) : count;
    addr_ik = AW'(AW'(i - CW'(1)) * AW'(MAX_MATRICES) + AW'(k - CW'(1)));
    addr_kj = AW'(AW'(k) * AW'(MAX_MATRICES) + AW'(j - CW'(1)));
    addr_ij = AW'(AW'(i - CW'(1)) * AW'(MAX_MATRICES) + AW'(j - CW'(1)));
  end

  // dimension store read port follows the sequencer
  always_comb begin
    unique case (state)
      S_INIT:  dim_raddr = DAW'(i - CW'(1));
      S_GETA:  dim_raddr = DAW'(j);
      default: dim_raddr = DAW'(k);
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      dim_mem[DAW'(count)] <= DIM_BITS'(item.dim);
    end
    dim_q <= dim_mem[dim_raddr];
  end

  // cost table: one write, two reads; a written cell is only read in a later
  // cell, after the write edge, so no bypass is needed
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      cost_mem[addr_ij] <= best;
    end
    cost_q0 <= cost_mem[addr_ik];
    cost_q1 <= cost_mem[addr_kj];
  end

  always_comb begin
    ctrl.mul1    = (state == S_MUL1);
    ctrl.mul2    = (state == S_MUL2);
    ctrl.acc     = (state == S_ACC);
    ctrl.first   = (k == i);
    ctrl.zero_ik = (k == i);
    ctrl.zero_kj = (k + CW'(1) == j);
  end

  mcmc_eval #(
    .DIM_BITS (DIM_BITS)
  ) u_eval (
    .clk     (clk),
    .ctrl    (ctrl),
    .dim_a   (dim_a),
    .dim_k   (dim_q),
    .dim_c   (dim_c),
    .cost_ik (cost_q0),
    .cost_kj (cost_q1),
    .best    (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
      m            <= '0;
      len          <= '0;
      i            <= '0;
      k            <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (!item.last) begin
              count <= count_next;
              ovf   <= ovf | !room;
            end else if (count_next < CW'(3)) begin
              // short chain: nothing to multiply
              result_valid    <= 1'b1;
              result.min_cost <= '0;
              result.overflow <= ovf | !room;
              count           <= '0;
              ovf             <= 1'b0;
            end else begin
              count <= count_next;
              ovf   <= ovf | !room;
              m     <= count_next - CW'(1);
              len   <= CW'(2);
              i     <= CW'(1);
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          k     <= i;
          state <= S_GETA;
        end
        S_GETA: begin
          dim_a <= dim_q;
          state <= S_GETC;
        end
        S_GETC: begin
          dim_c <= dim_q;
          state <= S_RD;
        end
        S_RD:   state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_ACC;
        S_ACC: begin
          if (k + CW'(1) == j) begin
            state <= S_WR;
          end else begin
            k     <= k + CW'(1);
            state <= S_RD;
          end
        end
        S_WR: begin
          if (len == m) begin
            result_valid    <= 1'b1;
            result.min_cost <= best;
            result.overflow <= ovf;
            count           <= '0;
            ovf             <= 1'b0;
            state           <= S_LOAD;
          end else begin
            if (j == m) begin
              len <= len + CW'(1);
              i   <= CW'(1);
            end else begin
              i <= i + CW'(1);
            end
            state <= S_INIT;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // a result only leaves with the sequencer back at load
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result while busy");

  // the split point stays inside its cell
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (k >= i && k < j))
    else $error("split point out of range");

  // cells never reach past the loaded chain
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (len >= CW'(2) && j <= m && m <= CW'(MAX_MATRICES)))
    else $error("cell out of range");

  // the load count never exceeds the store depth
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DIM_DEPTH))
    else $error("dimension count overrun");

endmodule
